/* hdl/ccpx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccpx_pkg
// Shared sizes, codes and controller/datapath handshake types for the
// cross-class pair XOR column core.
// ----------------------------------------------------------------------------
package ccpx_pkg;

    // Store geometry.
    localparam int MAX_CLASSES       = 8;
    localparam int MAX_OBS_PER_CLASS = 256;
    localparam int WORD_BITS         = 64;

    localparam int CLASS_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CCNT_W  = $clog2(MAX_CLASSES + 1);
    localparam int OBS_W   = (MAX_OBS_PER_CLASS > 1) ? $clog2(MAX_OBS_PER_CLASS) : 1;
    localparam int FILL_W  = $clog2(MAX_OBS_PER_CLASS + 1);
    localparam int ADDR_W  = CLASS_W + OBS_W;
    localparam int DEPTH   = MAX_CLASSES << OBS_W;

    // Item and result field widths.
    localparam int KIND_W       = 2;
    localparam int CLASS_ID_W   = 3;
    localparam int POS_W        = 8;
    localparam int WORD_W       = 64;
    localparam int LINE_IDX_W   = 21;
    localparam int STATUS_W     = 2;
    localparam int CLS_COUNT_W  = 4;

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SELECTED_COLUMN = CFG_IDX_W'(1);

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_NEXT   = 2'd1,
        KIND_REWIND = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NO_MORE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_INIT,
        S_OUTER,
        S_INNER,
        S_READ,
        S_EMIT
    } t_state;

    // Which class the single fill-count read port looks at.
    typedef enum logic [1:0] {
        FS_ITEM,
        FS_OUTER,
        FS_INNER
    } t_fill_sel;

    typedef struct packed {
        logic capture;     // latch the accepted item
        logic exec;        // immediate action of the item
        logic init_step;   // pull the inner class above the outer class
        logic outer_step;  // outer class check, advance if exhausted
        logic inner_step;  // inner class check, advance if exhausted
        logic read_step;   // take the pair words, bump inner observation
        logic fail_first;  // no pair found: mark enumeration done
        logic commit;      // save the cursor and line bookkeeping
        logic last;        // with commit: no further pair follows
        logic emit;        // move the pending result to the output register
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  enum_done;
        logic  nc_small;
        logic  outer_end;
        logic  outer_hit;
        logic  inner_in;
        logic  inner_hit;
        logic  out_free;
    } t_dp_stat;

endpackage

/* hdl/ccpx_item_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccpx_item_if
// Input item channel: load, next, rewind and clear requests.
// ----------------------------------------------------------------------------
interface ccpx_item_if
    import ccpx_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     kind;
    logic [CLASS_ID_W-1:0] class_id;
    logic [POS_W-1:0]      word_position;
    logic [WORD_W-1:0]     word_value;

    modport source (output valid, kind, class_id, word_position, word_value, input ready);
    modport sink   (input valid, kind, class_id, word_position, word_value, output ready);
endinterface

/* hdl/ccpx_line_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccpx_line_if
// Result channel: one result per accepted item.
// ----------------------------------------------------------------------------
interface ccpx_line_if
    import ccpx_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [WORD_W-1:0]     line_word;
    logic [LINE_IDX_W-1:0] line_index;
    logic                  last_line;
    logic [STATUS_W-1:0]   status;

    modport source (output valid, line_word, line_index, last_line, status, input ready);
    modport sink   (input valid, line_word, line_index, last_line, status, output ready);
endinterface

/* hdl/cross_class_pair_xor_column_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cross_class_pair_xor_column_core
// Keeps the selected column word of every loaded observation per class and
// returns, on request, the XOR of each cross-class observation pair.
//
//   channel   direction  handshake              payload
//   i_item    in         valid / ready          kind, class_id, word_position,
//                                               word_value
//   o_line    out        valid / ready          line_word, line_index,
//                                               last_line, status
//   i_cfg     in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Load, rewind and clear are latched, executed and then moved to the output
// register. A line request also runs the pair search twice, walking past
// classes and observation rows; the walk checks one fill count per cycle
// through the single fill-count read port.
// Reset is synchronous and active low; it empties all classes and rewinds.
// A result waits in the output register while the next item is taken in;
// a stalled result holds the block only when the next result is ready.
// ----------------------------------------------------------------------------
module cross_class_pair_xor_column_core
    import ccpx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ccpx_item_if.sink             i_item,
    ccpx_line_if.source           o_line,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd   w_cmd;
    t_dp_stat  w_stat;
    t_fill_sel w_fill_sel;
    logic      w_item_ready;

    // Configuration writes are always taken; the registers live in the datapath.
    // The user must write them only while idle; the block does not enforce it.
    assign o_cfg_ready  = 1'b1;
    assign i_item.ready = w_item_ready;

    // The controller walks the pair search one step per cycle.
    ccpx_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .o_item_ready (w_item_ready),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd),
        .o_fill_sel   (w_fill_sel)
    );

    // The datapath holds the store, the cursor and the result register.
    ccpx_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_item.kind),
        .i_class_id      (i_item.class_id),
        .i_word_position (i_item.word_position),
        .i_word_value    (i_item.word_value),
        .o_line_valid    (o_line.valid),
        .i_line_ready    (o_line.ready),
        .o_line_word     (o_line.line_word),
        .o_line_index    (o_line.line_index),
        .o_last_line     (o_line.last_line),
        .o_status        (o_line.status),
        .i_cmd           (w_cmd),
        .i_fill_sel      (w_fill_sel),
        .o_stat          (w_stat)
    );

endmodule

/* hdl/ccpx_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccpx_dp
// Datapath: configuration registers, observation store, fill counts,
// enumeration cursor and the result registers.
// ----------------------------------------------------------------------------
module ccpx_dp
    import ccpx_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration writes
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // item payload
    input  logic [KIND_W-1:0]      i_kind,
    input  logic [CLASS_ID_W-1:0]  i_class_id,
    input  logic [POS_W-1:0]       i_word_position,
    input  logic [WORD_W-1:0]      i_word_value,
    // result channel
    output logic                   o_line_valid,
    input  logic                   i_line_ready,
    output logic [WORD_W-1:0]      o_line_word,
    output logic [LINE_IDX_W-1:0]  o_line_index,
    output logic                   o_last_line,
    output logic [STATUS_W-1:0]    o_status,
    // controller link
    input  t_dp_cmd                i_cmd,
    input  t_fill_sel              i_fill_sel,
    output t_dp_stat               o_stat
);

    // Configuration.
    logic [CLS_COUNT_W-1:0] r_class_count;
    logic [POS_W-1:0]       r_sel_col;

    // Latched item.
    t_kind                 r_item_kind;
    logic [CLASS_ID_W-1:0] r_item_cls;
    logic [POS_W-1:0]      r_item_pos;
    logic [WORD_BITS-1:0]  r_item_word;

    // Store and fill counts.
    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rd_a;
    logic [WORD_BITS-1:0] r_rd_b;
    logic [FILL_W-1:0]    r_fill [MAX_CLASSES];

    // Saved cursor and working cursor.
    logic [CLASS_W-1:0]    r_st_ca;
    logic [FILL_W-1:0]     r_st_oa;
    logic [CCNT_W-1:0]     r_st_cb;
    logic [FILL_W-1:0]     r_st_ob;
    logic [CLASS_W-1:0]    r_ca;
    logic [FILL_W-1:0]     r_oa;
    logic [CCNT_W-1:0]     r_cb;
    logic [FILL_W-1:0]     r_ob;
    logic [LINE_IDX_W-1:0] r_lines;
    logic                  r_done;

    // Pending result and output register.
    logic [WORD_BITS-1:0]  r_p_word;
    logic [LINE_IDX_W-1:0] r_p_index;
    logic                  r_p_last;
    t_status               r_p_status;
    logic                  r_out_valid;
    logic [WORD_W-1:0]     r_out_word;
    logic [LINE_IDX_W-1:0] r_out_index;
    logic                  r_out_last;
    t_status               r_out_status;

    logic [CCNT_W-1:0]  w_nc;
    logic [CLASS_W-1:0] w_fill_idx;
    logic [FILL_W-1:0]  w_fill_q;
    logic               w_cls_ok;
    logic               w_pos_match;
    logic               w_full;
    logic               w_keep;
    logic               w_we;
    logic [ADDR_W-1:0]  w_wr_addr;
    logic [ADDR_W-1:0]  w_rd_addr_a;
    logic [ADDR_W-1:0]  w_rd_addr_b;

    // Class count saturates at the store size.
    assign w_nc = (int'(r_class_count) > MAX_CLASSES) ? CCNT_W'(MAX_CLASSES)
                                                      : CCNT_W'(r_class_count);

    always_comb begin
        unique case (i_fill_sel)
            FS_ITEM:  w_fill_idx = CLASS_W'(r_item_cls);
            FS_OUTER: w_fill_idx = r_ca;
            FS_INNER: w_fill_idx = r_cb[CLASS_W-1:0];
            default:  w_fill_idx = r_ca;
        endcase
    end

    assign w_fill_q    = r_fill[w_fill_idx];
    assign w_cls_ok    = int'(r_item_cls) < MAX_CLASSES;
    assign w_pos_match = (r_item_pos == r_sel_col);
    assign w_full      = (w_fill_q == FILL_W'(MAX_OBS_PER_CLASS));
    assign w_keep      = (r_item_kind == KIND_LOAD) && w_cls_ok && w_pos_match;
    assign w_we        = i_cmd.exec && w_keep && !w_full;
    assign w_wr_addr   = {w_fill_idx, w_fill_q[OBS_W-1:0]};
    assign w_rd_addr_a = {r_ca, r_oa[OBS_W-1:0]};
    assign w_rd_addr_b = {r_cb[CLASS_W-1:0], r_ob[OBS_W-1:0]};

    assign o_stat.kind      = r_item_kind;
    assign o_stat.enum_done = r_done;
    assign o_stat.nc_small  = (w_nc < CCNT_W'(2));
    assign o_stat.outer_end = (CCNT_W'(r_ca) + CCNT_W'(1)) >= w_nc;
    assign o_stat.outer_hit = (r_oa < w_fill_q);
    assign o_stat.inner_in  = (r_cb < w_nc);
    assign o_stat.inner_hit = (r_ob < w_fill_q);
    assign o_stat.out_free  = !r_out_valid || i_line_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_count <= CLS_COUNT_W'(2);
            r_sel_col     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CLASS_COUNT:     r_class_count <= i_cfg_data[CLS_COUNT_W-1:0];
                CFG_SELECTED_COLUMN: r_sel_col     <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // Item latch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item_kind <= t_kind'(i_kind);
            r_item_cls  <= i_class_id;
            r_item_pos  <= i_word_position;
            r_item_word <= i_word_value[WORD_BITS-1:0];
        end
    end

    // Observation store: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= r_item_word;
        end
        r_rd_a <= r_mem[w_rd_addr_a];
        r_rd_b <= r_mem[w_rd_addr_b];
    end

    // Fill counts, saved cursor, line counter and done flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CLASSES; i++) begin
                r_fill[i] <= '0;
            end
            r_st_ca <= '0;
            r_st_oa <= '0;
            r_st_cb <= CCNT_W'(1);
            r_st_ob <= '0;
            r_lines <= '0;
            r_done  <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                if (w_we) begin
                    r_fill[w_fill_idx] <= w_fill_q + FILL_W'(1);
                end
                if (r_item_kind == KIND_CLEAR) begin
                    for (int i = 0; i < MAX_CLASSES; i++) begin
                        r_fill[i] <= '0;
                    end
                end
                if (r_item_kind == KIND_REWIND || r_item_kind == KIND_CLEAR) begin
                    r_st_ca <= '0;
                    r_st_oa <= '0;
                    r_st_cb <= CCNT_W'(1);
                    r_st_ob <= '0;
                    r_lines <= '0;
                    r_done  <= 1'b0;
                end
            end
            if (i_cmd.fail_first) begin
                r_done <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_st_ca <= r_ca;
                r_st_oa <= r_oa;
                r_st_cb <= r_cb;
                r_st_ob <= r_ob;
                r_lines <= r_lines + LINE_IDX_W'(1);
            end
        end
    end

    // Working cursor: one step of the pair search per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_ca <= r_st_ca;
            r_oa <= r_st_oa;
            r_cb <= r_st_cb;
            r_ob <= r_st_ob;
        end
        if (i_cmd.init_step && (r_cb <= CCNT_W'(r_ca))) begin
            r_cb <= CCNT_W'(r_ca) + CCNT_W'(1);
            r_ob <= '0;
        end
        if (i_cmd.outer_step && !o_stat.outer_hit) begin
            r_ca <= r_ca + CLASS_W'(1);
            r_oa <= '0;
            r_cb <= CCNT_W'(r_ca) + CCNT_W'(2);
            r_ob <= '0;
        end
        if (i_cmd.inner_step) begin
            if (o_stat.inner_in) begin
                if (!o_stat.inner_hit) begin
                    r_cb <= r_cb + CCNT_W'(1);
                    r_ob <= '0;
                end
            end else begin
                r_oa <= r_oa + FILL_W'(1);
                r_cb <= CCNT_W'(r_ca) + CCNT_W'(1);
                r_ob <= '0;
            end
        end
        if (i_cmd.read_step) begin
            r_ob <= r_ob + FILL_W'(1);
        end
    end

    // Pending result fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_p_word  <= '0;
            r_p_index <= '0;
            r_p_last  <= 1'b0;
            if (w_keep && w_full) begin
                r_p_status <= ST_FULL;
            end else if (r_item_kind == KIND_NEXT) begin
                r_p_status <= ST_NO_MORE;
            end else begin
                r_p_status <= ST_OK;
            end
        end
        if (i_cmd.fail_first) begin
            r_p_status <= ST_NO_MORE;
        end
        if (i_cmd.read_step) begin
            r_p_word <= r_rd_a ^ r_rd_b;
        end
        if (i_cmd.commit) begin
            r_p_index  <= r_lines;
            r_p_last   <= i_cmd.last;
            r_p_status <= ST_OK;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_line_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_word   <= WORD_W'(r_p_word);
            r_out_index  <= r_p_index;
            r_out_last   <= r_p_last;
            r_out_status <= r_p_status;
        end
    end

    assign o_line_valid = r_out_valid;
    assign o_line_word  = r_out_word;
    assign o_line_index = r_out_index;
    assign o_last_line  = r_out_last;
    assign o_status     = r_out_status;

`ifndef SYNTH
    // The saved inner class always lies above the saved outer class.
    a_cursor_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st_cb > CCNT_W'(r_st_ca))
        else $error("saved inner class not above outer class");

    // A line is never committed once the enumeration is marked done.
    a_no_commit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !r_done)
        else $error("line committed after enumeration done");

    // A store write never lands beyond the class capacity.
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (w_fill_q < FILL_W'(MAX_OBS_PER_CLASS)))
        else $error("store write into full class");
`endif

endmodule

/* hdl/ccpx_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccpx_ctrl
// Controller: sequences item execution, the two pair searches of a line
// request and the hand-off of the result.
// ----------------------------------------------------------------------------
module ccpx_ctrl
    import ccpx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_item_valid,
    output logic      o_item_ready,
    input  t_dp_stat  i_stat,
    output t_dp_cmd   o_cmd,
    output t_fill_sel o_fill_sel
);

    t_state r_state;
    t_state n_state;
    logic   r_pass;
    logic   n_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_pass = 1'b0;
                if (i_stat.kind == KIND_NEXT && !i_stat.enum_done) begin
                    n_state = S_INIT;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_INIT: begin
                n_state = i_stat.nc_small ? S_EMIT : S_OUTER;
            end
            S_OUTER: begin
                if (i_stat.outer_end) begin
                    n_state = S_EMIT;
                end else if (i_stat.outer_hit) begin
                    n_state = S_INNER;
                end
            end
            S_INNER: begin
                if (!i_stat.inner_in) begin
                    n_state = S_OUTER;
                end else if (i_stat.inner_hit) begin
                    n_state = r_pass ? S_EMIT : S_READ;
                end
            end
            S_READ: begin
                n_pass  = 1'b1;
                n_state = S_INIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd        = '0;
        o_item_ready = 1'b0;
        o_fill_sel   = FS_OUTER;
        unique case (r_state)
            S_IDLE: begin
                o_item_ready  = 1'b1;
                o_cmd.capture = i_item_valid;
            end
            S_EXEC: begin
                o_fill_sel = FS_ITEM;
                o_cmd.exec = 1'b1;
            end
            S_INIT: begin
                if (i_stat.nc_small) begin
                    o_cmd.fail_first = !r_pass;
                    o_cmd.commit     = r_pass;
                    o_cmd.last       = 1'b1;
                end else begin
                    o_cmd.init_step = 1'b1;
                end
            end
            S_OUTER: begin
                o_fill_sel = FS_OUTER;
                if (i_stat.outer_end) begin
                    o_cmd.fail_first = !r_pass;
                    o_cmd.commit     = r_pass;
                    o_cmd.last       = 1'b1;
                end else begin
                    o_cmd.outer_step = 1'b1;
                end
            end
            S_INNER: begin
                o_fill_sel = FS_INNER;
                if (i_stat.inner_in && i_stat.inner_hit) begin
                    o_cmd.commit = r_pass;
                end else begin
                    o_cmd.inner_step = 1'b1;
                end
            end
            S_READ: begin
                o_cmd.read_step = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    // The result register is loaded only when its previous content is gone.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("result emitted over a waiting result");

    // The second search only starts after the pair words were taken.
    a_pass_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_INIT && r_pass))
        else $error("second pair search out of order");
`endif

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cross-class pair XOR column core. Requests go
// in through the item channel from a queue. An in-bench predictor of the
// class store and the pair walk works out each expected line result, and
// every result transfer is compared field by field against it. A directed
// opening comes first. Randomized phases follow, each under its own register
// setting and one of four patterns of sender gaps and receiver stalls. After that
// come a phase that fills one class past capacity and a long receiver
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
    import ccpx_pkg::*;

    // One request as it travels on the item channel.
    typedef struct packed {
        t_kind                 kind;
        logic [CLASS_ID_W-1:0] class_id;
        logic [POS_W-1:0]      word_position;
        logic [WORD_W-1:0]     word_value;
    } line_request_t;

    // One expected result, in the form the result channel carries it.
    typedef struct packed {
        logic [WORD_W-1:0]     word;
        logic [LINE_IDX_W-1:0] index;
        logic                  last;
        t_status               status;
    } line_result_t;

    // Position of the pair walk: outer class/observation, inner class/observation.
    typedef struct {
        int unsigned ca;
        int unsigned oa;
        int unsigned cb;
        int unsigned ob;
    } pair_cursor_t;

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ccpx_item_if item_bus ();
    ccpx_line_if line_bus ();

    cross_class_pair_xor_column_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_bus),
        .o_line      (line_bus),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Requests waiting to be offered, and results the block still owes us.
    line_request_t request_queue [$];
    line_result_t  pending_lines [$];

    // Gap and stall rates for the current phase, in percent.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // While set, the receiver refuses every result.
    bit   hold_off = 1'b0;
    event hold_off_go;

    int unsigned fail_count     = 0;
    int unsigned items_accepted = 0;
    int unsigned lines_checked  = 0;
    int unsigned full_reports   = 0;
    int unsigned no_more_count  = 0;
    int unsigned words_kept     = 0;
    int unsigned settings_used  = 0;

    // ------------------------------------------------------------------------
    // Predictor state: the kept words per class, their fill counts, the walk
    // cursor and the line bookkeeping, plus our copy of both registers.
    // ------------------------------------------------------------------------
    logic [WORD_W-1:0]     kept_word [MAX_CLASSES][MAX_OBS_PER_CLASS];
    int unsigned           fill_count [MAX_CLASSES];
    pair_cursor_t          walk;
    logic [LINE_IDX_W-1:0] line_counter;
    bit                    walk_exhausted;
    logic [CLS_COUNT_W-1:0] class_count_reg;
    logic [POS_W-1:0]      column_reg;

    function automatic void restart_walk();
        walk.ca        = 0;
        walk.oa        = 0;
        walk.cb        = 1;
        walk.ob        = 0;
        line_counter   = '0;
        walk_exhausted = 1'b0;
    endfunction

    // Moves the cursor forward to the first pair at or after it whose two
    // observations both exist. Class counts above the store size saturate,
    // and fewer than two classes never yield a pair.
    function automatic bit advance_to_pair(inout pair_cursor_t c);
        int unsigned nc;
        nc = (class_count_reg > MAX_CLASSES) ? MAX_CLASSES : class_count_reg;
        if (nc < 2) return 1'b0;
        if (c.cb <= c.ca) begin
            c.cb = c.ca + 1;
            c.ob = 0;
        end
        while (c.ca < nc - 1) begin
            if (c.oa < fill_count[c.ca]) begin
                while (c.cb < nc) begin
                    if (c.ob < fill_count[c.cb]) return 1'b1;
                    c.cb++;
                    c.ob = 0;
                end
                c.oa++;
            end else begin
                c.ca++;
                c.oa = 0;
            end
            c.cb = c.ca + 1;
            c.ob = 0;
        end
        return 1'b0;
    endfunction

    // Applies one accepted request to the predictor and returns its result.
    function automatic line_result_t compute_line_result(line_request_t req);
        line_result_t res;
        pair_cursor_t cur;
        res        = '0;
        res.status = ST_OK;
        case (req.kind)
            KIND_LOAD: begin
                // Only the word at the selected column is kept.
                if (req.word_position == column_reg) begin
                    if (fill_count[req.class_id] >= MAX_OBS_PER_CLASS) begin
                        res.status = ST_FULL;
                        full_reports++;
                    end else begin
                        kept_word[req.class_id][fill_count[req.class_id]] = req.word_value;
                        fill_count[req.class_id]++;
                        words_kept++;
                    end
                end
            end
            KIND_NEXT: begin
                cur = walk;
                if (walk_exhausted || !advance_to_pair(cur)) begin
                    walk_exhausted = 1'b1;
                    res.status     = ST_NO_MORE;
                    no_more_count++;
                end else begin
                    res.word  = kept_word[cur.ca][cur.oa] ^ kept_word[cur.cb][cur.ob];
                    res.index = line_counter;
                    line_counter++;
                    // Look ahead once more so the line can carry its last mark;
                    // the cursor keeps wherever that search stopped.
                    cur.ob++;
                    res.last = !advance_to_pair(cur);
                    walk     = cur;
                end
            end
            KIND_REWIND: begin
                restart_walk();
            end
            default: begin
                // Clear empties every class and rewinds as well.
                foreach (fill_count[k]) fill_count[k] = 0;
                restart_walk();
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Clock and run limit.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit; a correct run needs a small fraction of it.
    initial begin
        #12_000_000;
        $display("Run limit reached with %0d results outstanding", pending_lines.size());
        $display("TEST FAILED");
        $finish;
    end

    // The receiver hold-off: counted here so the sender keeps offering
    // requests while the block fills up and drops its input ready.
    initial begin
        @(hold_off_go);
        hold_off = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Item driver. A request accepted at this edge is run through the
    // predictor right away, so expectations queue up in transfer order.
    // An offered request is held until it is taken.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : item_driver
        line_request_t nxt;
        line_request_t taken;
        bit            offer;
        if (!i_rst_n) begin
            item_bus.valid <= 1'b0;
        end else begin
            if (item_bus.valid && item_bus.ready) begin
                taken.kind          = t_kind'(item_bus.kind);
                taken.class_id      = item_bus.class_id;
                taken.word_position = item_bus.word_position;
                taken.word_value    = item_bus.word_value;
                pending_lines.push_back(compute_line_result(taken));
                items_accepted++;
            end
            offer = item_bus.valid && !item_bus.ready;
            if (!offer && request_queue.size() != 0 &&
                $urandom_range(99, 0) >= send_idle_pct) begin
                nxt = request_queue.pop_front();
                item_bus.kind          <= nxt.kind;
                item_bus.class_id      <= nxt.class_id;
                item_bus.word_position <= nxt.word_position;
                item_bus.word_value    <= nxt.word_value;
                offer = 1'b1;
            end
            item_bus.valid <= offer;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls on ready, and a check of every transfer
    // against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : line_monitor
        line_result_t exp;
        line_bus.ready <= !hold_off && ($urandom_range(99, 0) >= recv_stall_pct);
        if (i_rst_n && line_bus.valid === 1'b1 && line_bus.ready) begin
            if (pending_lines.size() == 0) begin
                $error("result transfer with no request outstanding: word %h status %0d",
                       line_bus.line_word, line_bus.status);
                fail_count++;
            end else begin
                exp = pending_lines.pop_front();
                if (exp.status == ST_OK && exp.index != 0) lines_checked++;
                if (line_bus.line_word !== exp.word) begin
                    $error("line_word mismatch: expected %h, got %h", exp.word,
                           line_bus.line_word);
                    fail_count++;
                end
                if (line_bus.line_index !== exp.index) begin
                    $error("line_index mismatch: expected %0d, got %0d", exp.index,
                           line_bus.line_index);
                    fail_count++;
                end
                if (line_bus.last_line !== exp.last) begin
                    $error("last_line mismatch: expected %0d, got %0d", exp.last,
                           line_bus.last_line);
                    fail_count++;
                end
                if (line_bus.status !== exp.status) begin
                    $error("status mismatch: expected %0d, got %0d", exp.status,
                           line_bus.status);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void queue_request(t_kind k, logic [CLASS_ID_W-1:0] cls,
                                          logic [POS_W-1:0] pos, logic [WORD_W-1:0] val);
        line_request_t req;
        req.kind          = k;
        req.class_id      = cls;
        req.word_position = pos;
        req.word_value    = val;
        request_queue.push_back(req);
    endfunction

    // Next, rewind and clear ignore the other fields, so those carry noise.
    function automatic void queue_command(t_kind k);
        queue_request(k, $urandom_range(7, 0), $urandom_range(255, 0), random_word());
    endfunction

    function automatic void set_idling(int unsigned mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
        endcase
    endfunction

    // Config transfers happen only with the block idle, so our register copy
    // is updated at the accepting edge.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_CLASS_COUNT) class_count_reg = data[CLS_COUNT_W-1:0];
        else                        column_reg      = data;
    endtask

    // The upper bits of the class count write carry noise; only the low
    // nibble is meaningful.
    task automatic program_registers(logic [CLS_COUNT_W-1:0] cc, logic [POS_W-1:0] col);
        write_register(CFG_CLASS_COUNT, {4'($urandom_range(15, 0)), cc});
        write_register(CFG_SELECTED_COLUMN, col);
        settings_used++;
    endtask

    task automatic wait_until_drained();
        do @(posedge i_clk);
        while (request_queue.size() != 0 || item_bus.valid === 1'b1 ||
               pending_lines.size() != 0);
    endtask

    // A randomized phase: load a batch of words, mostly at the selected
    // column and into classes that take part, then mostly line requests with
    // loads, rewinds and the odd clear mixed in.
    task automatic queue_mixed_phase(int unsigned n_items);
        int unsigned span;
        int unsigned roll;
        t_kind       k;
        span = (class_count_reg >= 2 && class_count_reg <= MAX_CLASSES) ?
               class_count_reg : MAX_CLASSES;
        if ($urandom_range(1, 0) != 0) queue_command(KIND_CLEAR);
        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(99, 0);
            if (i < n_items * 2 / 5)  k = KIND_LOAD;
            else if (roll < 72)       k = KIND_NEXT;
            else if (roll < 85)       k = KIND_LOAD;
            else if (roll < 97)       k = KIND_REWIND;
            else                      k = KIND_CLEAR;
            if (k == KIND_LOAD) begin
                queue_request(KIND_LOAD,
                    ($urandom_range(4, 0) != 0) ? $urandom_range(span - 1, 0)
                                                : $urandom_range(7, 0),
                    ($urandom_range(4, 0) != 0) ? column_reg : $urandom_range(255, 0),
                    random_word());
            end else begin
                queue_command(k);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin : sequencer
        logic [CLS_COUNT_W-1:0] phase_count [12];
        logic [POS_W-1:0]       phase_column [7];
        logic [CLASS_ID_W-1:0]  full_class;
        logic [CLASS_ID_W-1:0]  side_class;

        // Class counts cover both values that give no lines, every in-range
        // value and several that saturate; the columns cover both extremes.
        phase_count  = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd8, 4'd15, 4'd9,
                         4'd5, 4'd4, 4'd7, 4'd6, 4'd12};
        phase_column = '{8'd0, 8'd255, 8'h5A, 8'hA5, 8'd255, 8'd0, 8'd17};

        i_rst_n                = 1'b0;
        i_cfg_valid            = 1'b0;
        i_cfg_index            = '0;
        i_cfg_data             = '0;
        item_bus.valid         = 1'b0;
        item_bus.kind          = KIND_LOAD;
        item_bus.class_id      = '0;
        item_bus.word_position = '0;
        item_bus.word_value    = '0;
        line_bus.ready         = 1'b0;

        // Predictor at its reset values: two classes, column zero.
        foreach (fill_count[k]) fill_count[k] = 0;
        class_count_reg = CLS_COUNT_W'(2);
        column_reg      = '0;
        restart_walk();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening, under the reset register values.
        set_idling(0);
        queue_command(KIND_NEXT);     // nothing stored: no more lines
        queue_command(KIND_NEXT);     // the done flag sticks
        queue_command(KIND_REWIND);
        queue_request(KIND_LOAD, 3'd0, 8'd0,   '1);
        queue_request(KIND_LOAD, 3'd0, 8'd255, 64'hDEAD_BEEF_0000_FFFF); // other column
        queue_request(KIND_LOAD, 3'd1, 8'd0,   '0);
        queue_request(KIND_LOAD, 3'd1, 8'd0,   64'hAAAA_AAAA_AAAA_AAAA);
        queue_request(KIND_LOAD, 3'd7, 8'd0,   64'h5555_5555_5555_5555); // outside the count
        queue_command(KIND_NEXT);
        queue_command(KIND_NEXT);     // marked last
        queue_command(KIND_NEXT);     // no more lines
        queue_request(KIND_LOAD, 3'd1, 8'd0,   64'h8000_0000_0000_0001);
        queue_command(KIND_NEXT);     // still done until rewind
        queue_command(KIND_REWIND);
        queue_command(KIND_NEXT);
        queue_command(KIND_NEXT);
        queue_command(KIND_NEXT);     // the late load shows up here
        queue_command(KIND_CLEAR);
        queue_command(KIND_NEXT);
        queue_request(KIND_LOAD, 3'd0, 8'd0,   random_word());
        queue_command(KIND_NEXT);     // one class empty: no pair
        queue_request(KIND_LOAD, 3'd1, 8'd0,   random_word());
        queue_command(KIND_REWIND);
        queue_command(KIND_NEXT);
        wait_until_drained();

        // Randomized phases, each with its own registers and one of four idling patterns.
        for (int p = 0; p < 12; p++) begin
            program_registers(phase_count[p],
                              (p < 7) ? phase_column[p] : $urandom_range(255, 0));
            set_idling(p);
            queue_mixed_phase(85);
            wait_until_drained();
        end

        // Overfill one class: two loads past capacity report full, and a
        // load at another column into the full class stays quiet.
        program_registers(4'd8, $urandom_range(255, 0));
        set_idling(3);
        full_class = $urandom_range(7, 0);
        side_class = full_class + 3'($urandom_range(7, 1));
        queue_command(KIND_CLEAR);
        for (int i = 0; i < MAX_OBS_PER_CLASS + 2; i++)
            queue_request(KIND_LOAD, full_class, column_reg, random_word());
        queue_request(KIND_LOAD, full_class, column_reg + 8'd1, random_word());
        for (int i = 0; i < 3; i++)
            queue_request(KIND_LOAD, side_class, column_reg, random_word());
        for (int i = 0; i < 30; i++)
            queue_command(($urandom_range(9, 0) == 0) ? KIND_REWIND : KIND_NEXT);
        wait_until_drained();

        // Back-pressure: the receiver holds off while line requests stream in.
        program_registers(4'd2, 8'h33);
        set_idling(0);
        queue_command(KIND_CLEAR);
        for (int i = 0; i < 12; i++)
            queue_request(KIND_LOAD, 3'(i % 2), column_reg, random_word());
        -> hold_off_go;
        for (int i = 0; i < 40; i++) queue_command(KIND_NEXT);
        wait_until_drained();

        // Give a stray extra result time to show up.
        repeat (40) @(posedge i_clk);
        if (pending_lines.size() != 0) begin
            $error("%0d expected results never arrived", pending_lines.size());
            fail_count++;
        end

        $display("Accepted %0d requests under %0d register settings: %0d words kept,",
                 items_accepted, settings_used + 1, words_kept);
        $display("%0d line results past the first, %0d full-class reports, %0d end-of-walk reports",
                 lines_checked, full_reports, no_more_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* cross_class_pair_xor_column_core.f */
hdl/ccpx_pkg.sv
hdl/ccpx_item_if.sv
hdl/ccpx_line_if.sv
hdl/ccpx_dp.sv
hdl/ccpx_ctrl.sv
hdl/cross_class_pair_xor_column_core.sv
dv/tb_top.sv
